>>> rtl/assert_macros.svh
// Assertion macros shared by the ordered array engine RTL.
// Needs nothing else; files that assert pull it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This check applies only while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// This check applies on every clock edge, during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/oae_pkg.sv
// Package for the ordered array engine: request and response types,
// opcode and status codes, and parameter defaults. It depends on nothing.
package oae_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DEL_VAL = 3'd1;
  localparam logic [2:0] OP_DEL_POS = 3'd2;
  localparam logic [2:0] OP_MODIFY  = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  position;
    logic [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_position;
    logic [4:0] used_count;
  } out_rsp_t;

endpackage

>>> rtl/oae_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Used by the ordered array engine; no dependencies.
module oae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ordered_array_engine.sv
// Ordered array engine top level: sequencer around one entry RAM.
// Depends on oae_pkg, oae_ram and assert_macros.svh.
//
// Usage: requests arrive on in_valid/in_ready carrying opcode, position and
// value; one response per request leaves on out_valid/out_ready with status,
// found position and the used count after the operation. cfg_we/cfg_wdata
// write the capacity register at any clock edge.
// The entries live in a RAM with one read and one write per cycle, so every
// shift or scan walks the array one entry per cycle. By operation:
//   modify, unknown opcodes and rejected requests: idle, then done, which
//   loads the output register and returns to idle for the next request;
//   search, delete by value, delete by position: a run state reads the
//   entries one by one, then done (search stops at its first match);
//   insert: run moves the entries from the insert position up one slot, a
//   last state writes the new value, then done; with nothing to move it skips run.
// After reset a clearing pass writes zero to all DEPTH entries, one per
// cycle, and in_ready stays low until the pass ends.
// A finished response sits in the output register; when the receiver stalls
// a new request can still be accepted and worked on, and its response waits
// in the sequencer until the output register is free.
module ordered_array_engine #(
  parameter int DEPTH      = oae_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = oae_pkg::ELEM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  oae_pkg::in_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output oae_pkg::out_rsp_t out_rsp,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata
);

  import oae_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int KW = (PW > 5) ? PW : 5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_LAST,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [4:0]            cap_r, cap_nxt;
  logic [PW-1:0]         used_r, used_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [4:0]            pos_r, pos_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [PW-1:0]         ptr_r, ptr_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic                  rv_r, rv_nxt;
  logic [PW-1:0]         raddr_r, raddr_nxt;
  logic                  hit_r, hit_nxt;
  logic [4:0]            hit_pos_r, hit_pos_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [4:0]            res_found_r, res_found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_rsp_t              out_rsp_r, out_rsp_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  logic [KW-1:0]         cap_k, size_k, pos_k, used_k, pos_m1_k, used_k_r;
  logic [63:0]           val_ext;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic [PW-1:0]         waddr_up, waddr_dn;
  logic [KW-1:0]         hit_pos_k, pos_r_m1_k;

  oae_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Effective size is the capacity clamped to 1..DEPTH.
  assign cap_k  = KW'(cap_r);
  assign size_k = (cap_k == '0) ? KW'(1) :
                  ((cap_k > KW'(DEPTH)) ? KW'(DEPTH) : cap_k);
  assign pos_k    = KW'(in_req.position);
  assign used_k   = KW'(used_r);
  assign used_k_r = used_k - KW'(1);
  assign pos_m1_k = pos_k - KW'(1);
  assign val_ext  = {32'd0, in_req.value};

  // The slot just past the last entry of a full array reads as zero.
  assign rd_data    = (raddr_r == PW'(DEPTH)) ? '0 : ram_rdata;
  assign waddr_up   = raddr_r + PW'(1);
  assign waddr_dn   = raddr_r - PW'(1);
  assign hit_pos_k  = KW'(raddr_r) + KW'(1);
  assign pos_r_m1_k = KW'(pos_r) - KW'(1);

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    used_nxt       = used_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    rv_nxt         = 1'b0;
    raddr_nxt      = raddr_r;
    hit_nxt        = hit_r;
    hit_pos_nxt    = hit_pos_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rsp_nxt    = out_rsp_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        if (ptr_r == PW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_req.opcode;
          pos_nxt        = in_req.position;
          val_nxt        = val_ext[ELEM_WIDTH-1:0];
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
          case (in_req.opcode)
            OP_INSERT: begin
              if (pos_k == '0 || pos_k > size_k) begin
                res_status_nxt = ST_RANGE;
              end else if (used_k >= size_k) begin
                res_status_nxt = ST_FULL;
              end else if (used_k >= pos_k) begin
                // Move entries pos-1 .. used-1 up one slot, top first.
                ptr_nxt   = PW'(used_k_r);
                cnt_nxt   = PW'(used_k - pos_k + KW'(1));
                state_nxt = S_RUN;
              end else begin
                state_nxt = S_LAST;
              end
            end
            OP_DEL_VAL, OP_SEARCH: begin
              if (used_r == '0) begin
                res_status_nxt = ST_MISS;
              end else begin
                ptr_nxt   = '0;
                cnt_nxt   = used_r;
                hit_nxt   = 1'b0;
                state_nxt = S_RUN;
              end
            end
            OP_DEL_POS: begin
              if (pos_k == '0 || pos_k > used_k) begin
                res_status_nxt = ST_RANGE;
              end else begin
                // Reads slots pos .. used; each lands one slot lower.
                ptr_nxt   = PW'(pos_k);
                cnt_nxt   = PW'(used_k - pos_k + KW'(1));
                hit_nxt   = 1'b1;
                state_nxt = S_RUN;
              end
            end
            OP_MODIFY: begin
              if (pos_k == '0 || pos_k > size_k) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_m1_k[AW-1:0];
                ram_wdata = val_ext[ELEM_WIDTH-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        // Issue the next read.
        if (cnt_r != '0) begin
          ram_re    = (ptr_r != PW'(DEPTH));
          ram_raddr = ptr_r[AW-1:0];
          rv_nxt    = 1'b1;
          raddr_nxt = ptr_r;
          cnt_nxt   = cnt_r - PW'(1);
          ptr_nxt   = (op_r == OP_INSERT) ? (ptr_r - PW'(1)) : (ptr_r + PW'(1));
        end
        // Handle the data read in the previous cycle.
        if (rv_r) begin
          if (op_r == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = waddr_up[AW-1:0];
            ram_wdata = rd_data;
          end else if (hit_r) begin
            if (op_r != OP_SEARCH) begin
              ram_we    = 1'b1;
              ram_waddr = waddr_dn[AW-1:0];
              ram_wdata = rd_data;
            end
          end else if (rd_data == val_r) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = hit_pos_k[4:0];
            if (op_r == OP_SEARCH) begin
              cnt_nxt = '0;
            end
          end
        end
        if (cnt_r == '0 && !rv_r) begin
          state_nxt = S_DONE;
          case (op_r)
            OP_INSERT: begin
              state_nxt = S_LAST;
            end
            OP_DEL_VAL: begin
              if (hit_r) begin
                used_nxt = used_r - PW'(1);
              end else begin
                res_status_nxt = ST_MISS;
              end
            end
            OP_DEL_POS: begin
              used_nxt = used_r - PW'(1);
            end
            OP_SEARCH: begin
              if (hit_r) begin
                res_found_nxt = hit_pos_r;
              end else begin
                res_status_nxt = ST_MISS;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r_m1_k[AW-1:0];
        ram_wdata = val_r;
        used_nxt  = used_r + PW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_rsp_nxt.status         = res_status_r;
          out_rsp_nxt.found_position = res_found_r;
          out_rsp_nxt.used_count     = used_k[4:0];
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cap_r       <= CAP_RESET;
      used_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    raddr_r      <= raddr_nxt;
    hit_pos_r    <= hit_pos_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  // A shift never writes the slot it is reading in the same cycle.
  `ASSERT_RST(a_no_rw_clash, clk, rst_n,
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "RAM read and write hit one slot")
  `ASSERT_RST(a_used_bound, clk, rst_n,
    used_r <= PW'(DEPTH), "used count beyond depth")
  `ASSERT_RST(a_rsp_from_done, clk, rst_n,
    $rose(out_valid_r) |-> $past(state_r == S_DONE), "response raised outside done state")
  `ASSERT_RST(a_read_counted, clk, rst_n,
    rv_r |-> $past(cnt_r != '0), "read data without an issued read")

endmodule
